// ===== rtl/cfc_pkg.sv =====
`timescale 1ns / 1ps

package cfc_pkg;

    // Field widths
    localparam int unsigned ByteW    = 8;
    localparam int unsigned HalfW    = 16;
    localparam int unsigned WordW    = 32;
    localparam int unsigned CountW   = 33;
    localparam int unsigned PlenW    = 26;
    localparam int unsigned CfgIdxW  = 4;
    localparam int unsigned CfgDataW = 16;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_EXPECTED_VERSION = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_TYPE_FIRST       = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_TYPE_LAST        = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_BIG_ENDIAN       = 4'd3;

    // Configuration reset values
    localparam logic [HalfW-1:0] RST_EXPECTED_VERSION = 16'd1;
    localparam logic [HalfW-1:0] RST_TYPE_FIRST       = 16'd0;
    localparam logic [HalfW-1:0] RST_TYPE_LAST        = 16'd7;
    localparam logic             RST_BIG_ENDIAN       = 1'b0;

    // CRC-32, reflected form
    localparam logic [WordW-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WordW-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // Declared length limits (declared length counts the bytes after it)
    localparam logic [WordW-1:0] MIN_DECLARED_LENGTH = 32'd8;
    localparam logic [WordW-1:0] MAX_FRAME_LENGTH    = 32'h0400_0000;

    // Verdict codes
    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_SHORT_HEADER = 3'd1,
        STATUS_LEN_MISMATCH = 3'd2,
        STATUS_LEN_RANGE    = 3'd3,
        STATUS_CRC          = 3'd4,
        STATUS_VERSION      = 3'd5,
        STATUS_TYPE         = 3'd6
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [HalfW-1:0]  msg_type;
        logic [PlenW-1:0]  payload_length;
    } t_result;

    typedef struct packed {
        logic [HalfW-1:0] expected_version;
        logic [HalfW-1:0] type_first;
        logic [HalfW-1:0] type_last;
        logic             big_endian;
    } t_config;

endpackage

// ===== rtl/cfc_in_if.sv =====
`timescale 1ns / 1ps

interface cfc_in_if;
    logic                       valid;
    logic                       ready;
    logic [cfc_pkg::ByteW-1:0]  byte_value;
    logic                       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// ===== rtl/cfc_out_if.sv =====
`timescale 1ns / 1ps

interface cfc_out_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 status;
    logic [cfc_pkg::HalfW-1:0]  msg_type;
    logic [cfc_pkg::PlenW-1:0]  payload_length;

    modport source (output valid, output status, output msg_type, output payload_length,
                    input ready);
    modport sink   (input valid, input status, input msg_type, input payload_length,
                    output ready);
endinterface

// ===== rtl/cfc_cfg_if.sv =====
`timescale 1ns / 1ps

interface cfc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cfc_pkg::CfgIdxW-1:0]   index;
    logic [cfc_pkg::CfgDataW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/crc_frame_checker_top.sv =====
`timescale 1ns / 1ps

// The final byte's transfer loads the input register; its verdict enters the result register
// as that byte steps on, which a verdict still waiting for the sink stalls. Throughput: one
// byte per cycle while nothing stalls; the byte-wide CRC update and the checks sit in one stage.
// Reset (i_rst_n low, synchronous) empties both stages, clears the frame state and
// restores the configuration registers to their defaults.
module crc_frame_checker_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cfc_in_if.sink         i_in_ch,
    cfc_out_if.source      o_res_ch,
    cfc_cfg_if.sink        i_cfg_ch
);

    cfc_pkg::t_config          r_cfg;
    logic                      r_s1_valid;
    logic [cfc_pkg::ByteW-1:0] r_s1_byte;
    logic                      r_s1_last;
    logic                      r_out_valid;
    cfc_pkg::t_result          r_out;

    cfc_pkg::t_result          w_result;
    logic                      w_stall;
    logic                      w_step;

    // Configuration writes are always taken
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= cfc_pkg::RST_EXPECTED_VERSION;
            r_cfg.type_first       <= cfc_pkg::RST_TYPE_FIRST;
            r_cfg.type_last        <= cfc_pkg::RST_TYPE_LAST;
            r_cfg.big_endian       <= cfc_pkg::RST_BIG_ENDIAN;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                cfc_pkg::REG_EXPECTED_VERSION: r_cfg.expected_version <= i_cfg_ch.data;
                cfc_pkg::REG_TYPE_FIRST:       r_cfg.type_first       <= i_cfg_ch.data;
                cfc_pkg::REG_TYPE_LAST:        r_cfg.type_last        <= i_cfg_ch.data;
                cfc_pkg::REG_BIG_ENDIAN:       r_cfg.big_endian       <= i_cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    // Hold the input and result registers while a verdict waits and the sink is not taking it
    assign w_stall       = r_out_valid && !o_res_ch.ready;
    assign w_step        = r_s1_valid && !w_stall;
    assign i_in_ch.ready = !r_s1_valid || !w_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_s1_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_s1_byte <= i_in_ch.byte_value;
            r_s1_last <= i_in_ch.last_byte;
        end
    end

    cfc_frame_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (w_step),
        .i_byte   (r_s1_byte),
        .i_last   (r_s1_last),
        .o_result (w_result)
    );

    // Result register: load a verdict on the final byte, drop it on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_s1_last) begin
            r_out <= w_result;
        end
    end

    assign o_res_ch.valid          = r_out_valid;
    assign o_res_ch.status         = r_out.status;
    assign o_res_ch.msg_type       = r_out.msg_type;
    assign o_res_ch.payload_length = r_out.payload_length;

endmodule

// ===== rtl/cfc_frame_check.sv =====
`timescale 1ns / 1ps

module cfc_frame_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cfc_pkg::t_config           i_cfg,
    input  logic                       i_step,
    input  logic [cfc_pkg::ByteW-1:0]  i_byte,
    input  logic                       i_last,
    output cfc_pkg::t_result           o_result
);

    // Frame state
    logic [cfc_pkg::CountW-1:0] r_count;
    logic [cfc_pkg::WordW-1:0]  r_declared;
    logic [cfc_pkg::WordW-1:0]  r_sent_crc;
    logic [cfc_pkg::WordW-1:0]  r_crc;
    logic [cfc_pkg::HalfW-1:0]  r_version;
    logic [cfc_pkg::HalfW-1:0]  r_type;

    logic [cfc_pkg::CountW-1:0] n_count;
    logic [cfc_pkg::WordW-1:0]  n_declared;
    logic [cfc_pkg::WordW-1:0]  n_sent_crc;
    logic [cfc_pkg::WordW-1:0]  n_crc;
    logic [cfc_pkg::HalfW-1:0]  n_version;
    logic [cfc_pkg::HalfW-1:0]  n_type;

    logic [cfc_pkg::CountW-1:0] w_after_len;
    logic [cfc_pkg::WordW-1:0]  w_plen_full;

    // One byte through the reflected CRC-32
    function automatic logic [cfc_pkg::WordW-1:0] crc_byte(
        input logic [cfc_pkg::WordW-1:0] crc_in,
        input logic [cfc_pkg::ByteW-1:0] b
    );
        logic [cfc_pkg::WordW-1:0] c;
        c = crc_in ^ {{(cfc_pkg::WordW-cfc_pkg::ByteW){1'b0}}, b};
        for (int k = 0; k < cfc_pkg::ByteW; k++) begin
            c = (c >> 1) ^ (c[0] ? cfc_pkg::CRC_POLY : '0);
        end
        return c;
    endfunction

    // Place a byte into a 4-byte field
    function automatic logic [cfc_pkg::WordW-1:0] place32(
        input logic [cfc_pkg::WordW-1:0] field,
        input logic [cfc_pkg::ByteW-1:0] b,
        input logic [1:0]                off,
        input logic                      be
    );
        logic [cfc_pkg::WordW-1:0] le;
        le = field;
        le[off*8 +: 8] = le[off*8 +: 8] | b;
        return be ? {field[23:0], b} : le;
    endfunction

    // Place a byte into a 2-byte field
    function automatic logic [cfc_pkg::HalfW-1:0] place16(
        input logic [cfc_pkg::HalfW-1:0] field,
        input logic [cfc_pkg::ByteW-1:0] b,
        input logic                      off,
        input logic                      be
    );
        logic [cfc_pkg::HalfW-1:0] le;
        le = off ? (field | {b, 8'd0}) : (field | {8'd0, b});
        return be ? {field[7:0], b} : le;
    endfunction

    // Route the byte to its field by position in the frame
    always_comb begin
        n_declared = r_declared;
        n_sent_crc = r_sent_crc;
        n_crc      = r_crc;
        n_version  = r_version;
        n_type     = r_type;
        if (r_count < 33'd4) begin
            n_declared = place32(r_declared, i_byte, r_count[1:0], i_cfg.big_endian);
        end else if (r_count < 33'd8) begin
            n_sent_crc = place32(r_sent_crc, i_byte, r_count[1:0], i_cfg.big_endian);
        end else begin
            n_crc = crc_byte(r_crc, i_byte);
            if (r_count < 33'd10) begin
                n_version = place16(r_version, i_byte, r_count[0], i_cfg.big_endian);
            end else if (r_count < 33'd12) begin
                n_type = place16(r_type, i_byte, r_count[0], i_cfg.big_endian);
            end
        end
        // saturate the byte count
        n_count = (&r_count) ? r_count : r_count + 33'd1;
    end

    // Verdict in check order, from the state after this byte
    assign w_after_len = n_count - 33'd4;
    assign w_plen_full = n_declared - cfc_pkg::MIN_DECLARED_LENGTH;

    always_comb begin
        o_result.msg_type       = (n_count >= 33'd12) ? n_type : '0;
        o_result.payload_length = '0;
        if (n_count < 33'd4) begin
            o_result.status = cfc_pkg::STATUS_SHORT_HEADER;
        end else if ({1'b0, n_declared} != w_after_len) begin
            o_result.status = cfc_pkg::STATUS_LEN_MISMATCH;
        end else if (n_declared < cfc_pkg::MIN_DECLARED_LENGTH ||
                     n_declared > cfc_pkg::MAX_FRAME_LENGTH) begin
            o_result.status = cfc_pkg::STATUS_LEN_RANGE;
        end else if ((n_crc ^ cfc_pkg::CRC_INIT) != n_sent_crc) begin
            o_result.status = cfc_pkg::STATUS_CRC;
        end else if (n_version != i_cfg.expected_version) begin
            o_result.status = cfc_pkg::STATUS_VERSION;
        end else if (n_type < i_cfg.type_first || n_type > i_cfg.type_last) begin
            o_result.status = cfc_pkg::STATUS_TYPE;
        end else begin
            o_result.status         = cfc_pkg::STATUS_OK;
            o_result.payload_length = w_plen_full[cfc_pkg::PlenW-1:0];
        end
    end

    // Advance the frame state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count    <= '0;
            r_declared <= '0;
            r_sent_crc <= '0;
            r_crc      <= cfc_pkg::CRC_INIT;
            r_version  <= '0;
            r_type     <= '0;
        end else if (i_step) begin
            r_count    <= n_count;
            r_declared <= n_declared;
            r_sent_crc <= n_sent_crc;
            r_crc      <= n_crc;
            r_version  <= n_version;
            r_type     <= n_type;
        end
    end

endmodule

// ===== bench/tb_crc_frame_checker_top.sv =====
`timescale 1ns / 1ps

module tb_crc_frame_checker_top;
    import cfc_pkg::*;

    localparam int unsigned HalfPeriod   = 4;
    localparam int unsigned ResetCycles  = 11;
    localparam int unsigned SettleCycles = 6;
    localparam int unsigned IdlePct      = 23;
    localparam int unsigned ByteTarget   = 1700;
    localparam int unsigned PhaseBytes   = 220;

    // Indexes past the register list; writes there must change nothing
    localparam logic [CfgIdxW-1:0] REG_SPARE_LOW  = 4'd4;
    localparam logic [CfgIdxW-1:0] REG_SPARE_HIGH = 4'd15;
    localparam logic [CountW-1:0]  COUNT_SAT      = '1;

    typedef enum logic [1:0] {
        ACT_BYTE,
        ACT_CFG,
        ACT_DRAIN
    } t_act_kind;

    typedef struct packed {
        t_act_kind            kind;
        logic [ByteW-1:0]     byte_value;
        logic                 last_byte;
        logic [CfgIdxW-1:0]   cfg_index;
        logic [CfgDataW-1:0]  cfg_data;
    } t_action;

    typedef enum logic [2:0] {
        FRM_GOOD,
        FRM_BAD_CRC,
        FRM_BAD_LEN,
        FRM_TRUNC,
        FRM_TINY,
        FRM_NOISE
    } t_frame_kind;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cfc_in_if  in_ch ();
    cfc_out_if res_ch ();
    cfc_cfg_if cfg_ch ();

    crc_frame_checker_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_res_ch (res_ch),
        .i_cfg_ch (cfg_ch)
    );

    // Transfers still to be sent, in wire order, with register writes between them
    t_action send_plan[$];
    t_result verdicts_due[$];
    int unsigned queued_bytes = 0;
    int unsigned bytes_moved  = 0;
    int unsigned settle_left  = 0;
    int unsigned mon_cycles   = 0;
    int unsigned fail_count   = 0;

    // Configuration as the block holds it, and as the frame builder expects it to be
    t_config active_cfg;
    t_config planned_cfg;

    // Bench model of the checker's frame state
    logic [CountW-1:0] frm_count;
    logic [WordW-1:0]  frm_declared;
    logic [WordW-1:0]  frm_crc_sent;
    logic [WordW-1:0]  frm_crc_run;
    logic [HalfW-1:0]  frm_version;
    logic [HalfW-1:0]  frm_type;

    always begin
        #HalfPeriod i_clk = 1'b1;
        #HalfPeriod i_clk = 1'b0;
    end

    function automatic logic [WordW-1:0] crc32_update(logic [WordW-1:0] crc,
                                                      logic [ByteW-1:0] b);
        logic [WordW-1:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [WordW-1:0] place_word(logic [WordW-1:0] f, logic [ByteW-1:0] b,
                                                    logic [1:0] off, logic big);
        if (big) begin
            return {f[23:0], b};
        end
        return f | ({24'd0, b} << (8 * off));
    endfunction

    function automatic logic [HalfW-1:0] place_half(logic [HalfW-1:0] f, logic [ByteW-1:0] b,
                                                    logic off, logic big);
        if (big) begin
            return {f[7:0], b};
        end
        return f | ({8'd0, b} << (8 * off));
    endfunction

    // Byte i (wire order) of an nb-byte field
    function automatic logic [ByteW-1:0] field_byte(logic [WordW-1:0] v, int nb, int i,
                                                    logic big);
        return big ? v[8 * (nb - 1 - i) +: 8] : v[8 * i +: 8];
    endfunction

    function automatic t_config reg_write(t_config c, logic [CfgIdxW-1:0] idx,
                                          logic [CfgDataW-1:0] d);
        t_config r;
        r = c;
        case (idx)
            REG_EXPECTED_VERSION: r.expected_version = d;
            REG_TYPE_FIRST:       r.type_first = d;
            REG_TYPE_LAST:        r.type_last = d;
            REG_BIG_ENDIAN:       r.big_endian = d[0];
            default:              r = c;
        endcase
        return r;
    endfunction

    task automatic clear_frame();
        frm_count    = '0;
        frm_declared = '0;
        frm_crc_sent = '0;
        frm_crc_run  = CRC_INIT;
        frm_version  = '0;
        frm_type     = '0;
    endtask

    // Fold one byte into the frame state; on the final byte queue the verdict
    task automatic absorb_byte(input logic [ByteW-1:0] b, input logic last);
        logic [CountW-1:0] total;
        logic [WordW-1:0]  plen;
        t_result           v;
        if (frm_count < 4) begin
            frm_declared = place_word(frm_declared, b, frm_count[1:0], active_cfg.big_endian);
        end else if (frm_count < 8) begin
            frm_crc_sent = place_word(frm_crc_sent, b, frm_count[1:0], active_cfg.big_endian);
        end else begin
            frm_crc_run = crc32_update(frm_crc_run, b);
            if (frm_count < 10) begin
                frm_version = place_half(frm_version, b, frm_count[0], active_cfg.big_endian);
            end else if (frm_count < 12) begin
                frm_type = place_half(frm_type, b, frm_count[0], active_cfg.big_endian);
            end
        end
        if (frm_count != COUNT_SAT) begin
            frm_count = frm_count + 1'b1;
        end
        if (last) begin
            total            = frm_count;
            v.msg_type       = (total >= 12) ? frm_type : '0;
            v.payload_length = '0;
            if (total < 4) begin
                v.status = STATUS_SHORT_HEADER;
            end else if ({1'b0, frm_declared} != total - 4) begin
                v.status = STATUS_LEN_MISMATCH;
            end else if (frm_declared < MIN_DECLARED_LENGTH ||
                         frm_declared > MAX_FRAME_LENGTH) begin
                v.status = STATUS_LEN_RANGE;
            end else if ((frm_crc_run ^ CRC_INIT) != frm_crc_sent) begin
                v.status = STATUS_CRC;
            end else if (frm_version != active_cfg.expected_version) begin
                v.status = STATUS_VERSION;
            end else if (frm_type < active_cfg.type_first ||
                         frm_type > active_cfg.type_last) begin
                v.status = STATUS_TYPE;
            end else begin
                v.status         = STATUS_OK;
                plen             = frm_declared - MIN_DECLARED_LENGTH;
                v.payload_length = plen[PlenW-1:0];
            end
            verdicts_due.push_back(v);
            clear_frame();
        end
    endtask

    task automatic queue_byte(input logic [ByteW-1:0] b, input logic last);
        t_action a;
        a            = '0;
        a.kind       = ACT_BYTE;
        a.byte_value = b;
        a.last_byte  = last;
        send_plan.push_back(a);
        queued_bytes++;
    endtask

    task automatic queue_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
        t_action a;
        a           = '0;
        a.kind      = ACT_CFG;
        a.cfg_index = idx;
        a.cfg_data  = d;
        send_plan.push_back(a);
        planned_cfg = reg_write(planned_cfg, idx, d);
    endtask

    task automatic queue_drain();
        t_action a;
        a      = '0;
        a.kind = ACT_DRAIN;
        send_plan.push_back(a);
    endtask

    // Build one frame; split_at > 0 flips the byte order after that many bytes
    task automatic queue_frame(input t_frame_kind kind, input int unsigned payload_n,
                               input logic [HalfW-1:0] ver, input logic [HalfW-1:0] mtype,
                               input int unsigned split_at);
        logic [ByteW-1:0]    body[$];
        logic [ByteW-1:0]    wire_bytes[$];
        logic [WordW-1:0]    crc;
        logic [WordW-1:0]    decl;
        logic [CfgDataW-1:0] flip;
        int unsigned         n;
        for (int i = 0; i < 2; i++) begin
            body.push_back(field_byte({16'd0, ver}, 2, i, planned_cfg.big_endian));
        end
        for (int i = 0; i < 2; i++) begin
            body.push_back(field_byte({16'd0, mtype}, 2, i, planned_cfg.big_endian));
        end
        for (int i = 0; i < payload_n; i++) begin
            body.push_back(ByteW'($urandom_range(255)));
        end
        crc = CRC_INIT;
        foreach (body[i]) begin
            crc = crc32_update(crc, body[i]);
        end
        crc  = crc ^ CRC_INIT;
        decl = payload_n + MIN_DECLARED_LENGTH;
        if (kind == FRM_BAD_CRC) begin
            crc = crc ^ (32'd1 << $urandom_range(31));
        end
        if (kind == FRM_BAD_LEN) begin
            decl = decl ^ (32'd1 << $urandom_range(31));
        end
        if (kind == FRM_TINY) begin
            decl = payload_n;
        end
        for (int i = 0; i < 4; i++) begin
            wire_bytes.push_back(field_byte(decl, 4, i, planned_cfg.big_endian));
        end
        if (kind == FRM_TINY) begin
            for (int i = 0; i < payload_n; i++) begin
                wire_bytes.push_back(ByteW'($urandom_range(255)));
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                wire_bytes.push_back(field_byte(crc, 4, i, planned_cfg.big_endian));
            end
            foreach (body[i]) begin
                wire_bytes.push_back(body[i]);
            end
        end
        if (kind == FRM_NOISE) begin
            wire_bytes.delete();
            n = $urandom_range(24, 1);
            for (int i = 0; i < n; i++) begin
                wire_bytes.push_back(ByteW'($urandom_range(255)));
            end
        end
        n = wire_bytes.size();
        if (kind == FRM_TRUNC) begin
            n = $urandom_range(n - 1, 1);
        end
        for (int i = 0; i < n; i++) begin
            if (split_at != 0 && i == split_at) begin
                flip    = CfgDataW'($urandom);
                flip[0] = ~planned_cfg.big_endian;
                queue_cfg(REG_BIG_ENDIAN, flip);
            end
            queue_byte(wire_bytes[i], i == n - 1);
        end
    endtask

    // Byte and register-write driver
    always @(posedge i_clk) begin : frame_driver
        logic                in_go;
        logic                cfg_go;
        logic                nx_in_valid;
        logic                nx_last;
        logic [ByteW-1:0]    nx_byte;
        logic                nx_cfg_valid;
        logic [CfgIdxW-1:0]  nx_idx;
        logic [CfgDataW-1:0] nx_data;
        t_action             act;
        if (!i_rst_n) begin
            active_cfg = {RST_EXPECTED_VERSION, RST_TYPE_FIRST, RST_TYPE_LAST, RST_BIG_ENDIAN};
            clear_frame();
            settle_left = SettleCycles;
            in_ch.valid  <= 1'b0;
            cfg_ch.valid <= 1'b0;
        end else begin
            in_go  = in_ch.valid && in_ch.ready;
            cfg_go = cfg_ch.valid && cfg_ch.ready;
            if (in_go) begin
                absorb_byte(in_ch.byte_value, in_ch.last_byte);
                bytes_moved++;
            end
            if (cfg_go) begin
                active_cfg = reg_write(active_cfg, cfg_ch.index, cfg_ch.data);
            end

            // Count quiet cycles since the last transfer or outstanding verdict
            if (in_go || cfg_go || verdicts_due.size() != 0) begin
                settle_left = SettleCycles;
            end else if (settle_left != 0) begin
                settle_left--;
            end

            nx_in_valid  = in_ch.valid && !in_go;
            nx_byte      = in_ch.byte_value;
            nx_last      = in_ch.last_byte;
            nx_cfg_valid = cfg_ch.valid && !cfg_go;
            nx_idx       = cfg_ch.index;
            nx_data      = cfg_ch.data;

            // Advance the plan: bytes with random gaps, writes only once the block is quiet
            if (!nx_in_valid && !nx_cfg_valid && send_plan.size() != 0) begin
                act = send_plan[0];
                if (act.kind == ACT_BYTE) begin
                    if ((bytes_moved >= 700 && bytes_moved < 1000) ||
                        $urandom_range(99) >= IdlePct) begin
                        void'(send_plan.pop_front());
                        nx_in_valid = 1'b1;
                        nx_byte     = act.byte_value;
                        nx_last     = act.last_byte;
                    end
                end else if (settle_left == 0) begin
                    void'(send_plan.pop_front());
                    if (act.kind == ACT_CFG) begin
                        nx_cfg_valid = 1'b1;
                        nx_idx       = act.cfg_index;
                        nx_data      = act.cfg_data;
                    end
                end
            end

            in_ch.valid      <= nx_in_valid;
            in_ch.byte_value <= nx_byte;
            in_ch.last_byte  <= nx_last;
            cfg_ch.valid     <= nx_cfg_valid;
            cfg_ch.index     <= nx_idx;
            cfg_ch.data      <= nx_data;
        end
    end

    // Verdict monitor with random back-pressure
    always @(posedge i_clk) begin : verdict_monitor
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            mon_cycles++;
            if (res_ch.valid && res_ch.ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: verdict with none expected: status %0d type %h plen %0d",
                             $time, res_ch.status, res_ch.msg_type, res_ch.payload_length);
                    fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (res_ch.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, res_ch.status);
                        fail_count++;
                    end
                    if (res_ch.msg_type !== want.msg_type) begin
                        $display("%0t: msg_type expected %h actual %h",
                                 $time, want.msg_type, res_ch.msg_type);
                        fail_count++;
                    end
                    if (res_ch.payload_length !== want.payload_length) begin
                        $display("%0t: payload_length expected %0d actual %0d",
                                 $time, want.payload_length, res_ch.payload_length);
                        fail_count++;
                    end
                end
            end
            res_ch.ready <= (mon_cycles >= 600 && mon_cycles < 1200) ||
                            ($urandom_range(99) >= IdlePct);
        end
    end

    initial begin
        int unsigned      phase;
        int unsigned      next_phase_at;
        int unsigned      split;
        int unsigned      r;
        int unsigned      len;
        t_frame_kind      kind;
        logic [HalfW-1:0] ver;
        logic [HalfW-1:0] mtype;
        logic [HalfW-1:0] lo;
        logic [HalfW-1:0] hi;

        in_ch.valid      = 1'b0;
        in_ch.byte_value = '0;
        in_ch.last_byte  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        res_ch.ready     = 1'b0;
        planned_cfg = {RST_EXPECTED_VERSION, RST_TYPE_FIRST, RST_TYPE_LAST, RST_BIG_ENDIAN};

        // Directed: smallest good frame, one-byte frame, zero declared length, bad CRC
        queue_frame(FRM_GOOD, 0, RST_EXPECTED_VERSION, RST_TYPE_LAST, 0);
        queue_byte(8'hFF, 1'b1);
        queue_frame(FRM_TINY, 0, '0, '0, 0);
        queue_frame(FRM_BAD_CRC, 0, RST_EXPECTED_VERSION, '0, 0);

        // Random phases, each under its own register settings
        phase         = 0;
        split         = 0;
        next_phase_at = queued_bytes;
        while (queued_bytes < ByteTarget) begin
            if (queued_bytes >= next_phase_at) begin
                if (phase == 3) begin
                    queue_drain();
                end
                case (phase % 6)
                    0: begin ver = '1; lo = '0; hi = '1; end
                    1: begin ver = '0; lo = '1; hi = '1; end
                    2: begin
                        ver = HalfW'($urandom);
                        lo  = HalfW'($urandom);
                        hi  = HalfW'($urandom);
                    end
                    3: begin ver = HalfW'($urandom); lo = 16'd5; hi = 16'd2; end
                    4: begin ver = RST_EXPECTED_VERSION; lo = '0; hi = '0; end
                    default: begin
                        ver = RST_EXPECTED_VERSION;
                        lo  = RST_TYPE_FIRST;
                        hi  = RST_TYPE_LAST;
                    end
                endcase
                queue_cfg(REG_EXPECTED_VERSION, ver);
                queue_cfg(REG_TYPE_FIRST, lo);
                queue_cfg(REG_TYPE_LAST, hi);
                mtype    = HalfW'($urandom);
                mtype[0] = ~phase[0];
                queue_cfg(REG_BIG_ENDIAN, mtype);
                if (phase % 3 == 1) begin
                    queue_cfg(CfgIdxW'($urandom_range(REG_SPARE_HIGH, REG_SPARE_LOW)),
                              CfgDataW'($urandom));
                end
                split         = (phase == 2) ? $urandom_range(11, 1) : 0;
                phase++;
                next_phase_at += PhaseBytes;
            end

            r = $urandom_range(99);
            if (r < 70) begin
                kind = FRM_GOOD;
            end else if (r < 78) begin
                kind = FRM_BAD_CRC;
            end else if (r < 85) begin
                kind = FRM_BAD_LEN;
            end else if (r < 92) begin
                kind = FRM_TRUNC;
            end else if (r < 96) begin
                kind = FRM_TINY;
            end else begin
                kind = FRM_NOISE;
            end

            r = $urandom_range(99);
            if (kind == FRM_TINY) begin
                len = $urandom_range(7);
            end else if (r < 85) begin
                len = $urandom_range(12);
            end else if (r < 98) begin
                len = $urandom_range(48, 13);
            end else begin
                len = $urandom_range(200, 49);
            end

            r = $urandom_range(99);
            if (r < 80) begin
                ver = planned_cfg.expected_version;
            end else if (r < 85) begin
                ver = '0;
            end else if (r < 90) begin
                ver = '1;
            end else begin
                ver = HalfW'($urandom);
            end

            r = $urandom_range(99);
            if (r < 75 && planned_cfg.type_first <= planned_cfg.type_last) begin
                mtype = HalfW'($urandom_range(planned_cfg.type_last, planned_cfg.type_first));
            end else if (r < 82) begin
                mtype = '0;
            end else if (r < 89) begin
                mtype = '1;
            end else begin
                mtype = HalfW'($urandom);
            end

            // Keep the split frame intact so the byte-order flip lands inside its header
            if (split != 0) begin
                kind = FRM_GOOD;
            end
            queue_frame(kind, len, ver, mtype, split);
            split = 0;
        end

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every byte transferred, every verdict in, then let the pipe settle
        while (bytes_moved != queued_bytes) @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles * 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cfc_pkg.sv
rtl/cfc_in_if.sv
rtl/cfc_out_if.sv
rtl/cfc_cfg_if.sv
rtl/cfc_frame_check.sv
rtl/crc_frame_checker_top.sv
bench/tb_crc_frame_checker_top.sv
